### rtl/swt_pkg.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer package
// Result codes, byte constants and the result record shared by the tokenizer.
// ----------------------------------------------------------------------------
package swt_pkg;

    localparam logic [1:0] KIND_WORD_BYTE = 2'd0;
    localparam logic [1:0] KIND_WORD_END  = 2'd1;
    localparam logic [1:0] KIND_NO_WORD   = 2'd2;
    localparam logic [1:0] KIND_OPEN_ERR  = 2'd3;

    localparam logic [7:0] CHAR_EOT       = 8'h03;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_HASH      = 8'h23;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] word_byte;
        logic       end_of_command;
        logic       overflow;
    } result_t;

endpackage

### rtl/shell_word_tokenizer.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer
// Splits a shell command byte stream into words with quoting and escapes.
// ----------------------------------------------------------------------------
// Bytes arrive on the slave stream, one per transfer in s_tdata; byte 3 marks
// the end of text. Each byte yields zero or one result transfer on the master
// stream: m_tdata carries the word byte, m_tuser the result kind and the
// overflow flag, and m_tlast marks a word end that also ends a command.
// An accepted byte is held in an input register and classified when the
// output register can take its result, which is registered there. One byte
// is taken per cycle unless the receiver stalls, set by the single state
// update in the classification stage. When the receiver stalls, the
// pending result holds in the output register, one more byte may enter the
// input register, and s_tready then falls until the result is taken.
// Reset empties both registers and clears all quoting and word state.
// ----------------------------------------------------------------------------
module shell_word_tokenizer #(
    parameter int MAX_WORD = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] word_byte
    output logic       m_tlast,   // end_of_command
    output logic [2:0] m_tuser    // [1:0] kind, [2] overflow
);

    logic             in_valid_reg;
    logic [7:0]       in_data_reg;
    logic             out_valid_reg;
    logic [1:0]       out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_eoc_reg;
    logic             out_ovf_reg;
    logic             advance;
    logic             step;
    swt_pkg::result_t result;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    swt_core #(
        .MAX_WORD (MAX_WORD)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (in_data_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.valid)
        begin
            out_kind_reg <= result.kind;
            out_byte_reg <= result.word_byte;
            out_eoc_reg  <= result.end_of_command;
            out_ovf_reg  <= result.overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_eoc_reg;
    assign m_tuser  = {out_ovf_reg, out_kind_reg};

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("Input register lost a byte while the output was stalled.");

    a_eoc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1:0] == swt_pkg::KIND_WORD_END)
        else $error("Command end flagged on a result that is not a word end.");

    a_byte_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == swt_pkg::KIND_WORD_BYTE
                     || m_tuser[1:0] == swt_pkg::KIND_NO_WORD) |-> !m_tuser[2])
        else $error("Overflow flagged on a word byte or an empty end of text.");

    a_no_word_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != swt_pkg::KIND_WORD_BYTE |-> m_tdata == 8'd0)
        else $error("Non-byte result carries a data byte.");

endmodule

### rtl/swt_core.sv
// ----------------------------------------------------------------------------
// Shell word tokenizer core
// Holds the quoting, escape, comment and word length state and classifies
// one byte per cycle, when step is high, into at most one result.
// ----------------------------------------------------------------------------
module swt_core #(
    parameter int MAX_WORD = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       char_in,
    output swt_pkg::result_t result
);

    localparam int LW = $clog2(MAX_WORD + 1);

    logic          escape_reg, escape_next;
    logic          squote_reg, squote_next;
    logic          dquote_reg, dquote_next;
    logic          comment_reg, comment_next;
    logic [LW-1:0] length_reg, length_next;
    logic          ovf_reg, ovf_next;

    logic quoted;
    logic is_sep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg  <= 1'b0;
            squote_reg  <= 1'b0;
            dquote_reg  <= 1'b0;
            comment_reg <= 1'b0;
            length_reg  <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (step)
        begin
            escape_reg  <= escape_next;
            squote_reg  <= squote_next;
            dquote_reg  <= dquote_next;
            comment_reg <= comment_next;
            length_reg  <= length_next;
            ovf_reg     <= ovf_next;
        end
    end

    assign quoted = squote_reg | dquote_reg;
    assign is_sep = (char_in == swt_pkg::CHAR_SPACE) || (char_in == swt_pkg::CHAR_SEMICOLON)
                    || (char_in == swt_pkg::CHAR_NEWLINE);

    always_comb
    begin
        logic append;
        append       = 1'b0;
        escape_next  = escape_reg;
        squote_next  = squote_reg;
        dquote_next  = dquote_reg;
        comment_next = comment_reg;
        length_next  = length_reg;
        ovf_next     = ovf_reg;
        result       = '0;

        if (char_in == swt_pkg::CHAR_EOT)
        begin
            result.valid = 1'b1;
            if (length_reg == '0)
            begin
                result.kind = swt_pkg::KIND_NO_WORD;
            end
            else if (escape_reg || quoted)
            begin
                result.kind     = swt_pkg::KIND_OPEN_ERR;
                result.overflow = ovf_reg;
            end
            else
            begin
                result.kind           = swt_pkg::KIND_WORD_END;
                result.end_of_command = 1'b1;
                result.overflow       = ovf_reg;
            end
            escape_next  = 1'b0;
            squote_next  = 1'b0;
            dquote_next  = 1'b0;
            comment_next = 1'b0;
            length_next  = '0;
            ovf_next     = 1'b0;
        end
        else if (comment_reg)
        begin
            if (char_in == swt_pkg::CHAR_NEWLINE)
            begin
                comment_next = 1'b0;
            end
        end
        else if (escape_reg)
        begin
            escape_next = 1'b0;
            append      = (char_in != swt_pkg::CHAR_NEWLINE);
        end
        else if (char_in == swt_pkg::CHAR_BACKSLASH)
        begin
            escape_next = 1'b1;
        end
        else if (!dquote_reg && char_in == swt_pkg::CHAR_SQUOTE)
        begin
            squote_next = ~squote_reg;
        end
        else if (!squote_reg && char_in == swt_pkg::CHAR_DQUOTE)
        begin
            dquote_next = ~dquote_reg;
        end
        else if (!quoted && (is_sep || char_in == swt_pkg::CHAR_HASH))
        begin
            if (char_in == swt_pkg::CHAR_HASH)
            begin
                comment_next = 1'b1;
            end
            if (length_reg != '0)
            begin
                result.valid          = 1'b1;
                result.kind           = swt_pkg::KIND_WORD_END;
                result.end_of_command = (char_in != swt_pkg::CHAR_SPACE);
                result.overflow       = ovf_reg;
                length_next           = '0;
                ovf_next              = 1'b0;
            end
        end
        else
        begin
            append = 1'b1;
        end

        if (append)
        begin
            if (length_reg < LW'(MAX_WORD))
            begin
                length_next      = length_reg + LW'(1);
                result.valid     = 1'b1;
                result.kind      = swt_pkg::KIND_WORD_BYTE;
                result.word_byte = char_in;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

endmodule
